FILE: rtl/core/glyph_row_renderer_core_defines.svh
// assertion helpers used by the checker file
`ifndef GLYPH_ROW_RENDERER_CORE_DEFINES_SVH
`define GLYPH_ROW_RENDERER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GRR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/grr_pkg.sv
package grr_pkg;

    // font store geometry, depth must be a power of two
    localparam int FONT_WORDS     = 8192;
    localparam int MAX_GLYPH_ROWS = 32;
    localparam int AW             = $clog2(FONT_WORDS);
    localparam int ROW_W          = $clog2(MAX_GLYPH_ROWS + 1);

    // field widths
    localparam int FONT_ADDR_W = 13;
    localparam int FONT_WORD_W = 16;
    localparam int CODE_W      = 8;
    localparam int PIX_IDX_W   = 25;
    localparam int PITCH_W     = 13;
    localparam int HEIGHT_W    = 6;
    localparam int WORDS_W     = 6;
    localparam int CWIDTH_W    = 7;
    localparam int COLOR_W     = 32;

    // derived arithmetic widths
    localparam int YBASE_W   = CODE_W + HEIGHT_W;
    localparam int COLOFF_W  = CODE_W + CWIDTH_W;
    localparam int IDX_SUM_W = YBASE_W + PITCH_W + 1;
    localparam int BASE_W    = (AW > CODE_W + WORDS_W) ? AW : CODE_W + WORDS_W;
    localparam int LD_W      = (AW > FONT_ADDR_W) ? AW : FONT_ADDR_W;

    // configuration port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_PITCH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WORDS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CWIDTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FG     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BG     = 3'd5;

    localparam logic [PITCH_W-1:0]  RST_PITCH  = 13'd1024;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 6'd20;
    localparam logic [WORDS_W-1:0]  RST_WORDS  = 6'd20;
    localparam logic [CWIDTH_W-1:0] RST_CWIDTH = 7'd10;
    localparam logic [COLOR_W-1:0]  RST_FG     = 32'h00FF_CC00;
    localparam logic [COLOR_W-1:0]  RST_BG     = 32'h001A_1A1A;

    // item operations
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [FONT_ADDR_W-1:0] font_addr;
        logic [FONT_WORD_W-1:0] font_word;
        logic [CODE_W-1:0]      char_code;
        logic [CODE_W-1:0]      char_col;
        logic [CODE_W-1:0]      char_row;
    } t_in_item;

    typedef struct packed {
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [COLOR_W-1:0]   color_0;
        logic [COLOR_W-1:0]   color_1;
        logic [COLOR_W-1:0]   color_2;
        logic [COLOR_W-1:0]   color_3;
        logic [COLOR_W-1:0]   color_4;
        logic [COLOR_W-1:0]   color_5;
        logic [COLOR_W-1:0]   color_6;
        logic [COLOR_W-1:0]   color_7;
        logic [COLOR_W-1:0]   color_8;
        logic [COLOR_W-1:0]   color_9;
        logic                 last_row;
    } t_out_item;

endpackage

FILE: rtl/core/grr_ram.sv
module grr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/glyph_row_renderer_core.sv
// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
// out      | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
// cfg      | input     | psel, penable, pwrite      | paddr, pwdata, prdata
//
// a load item writes the font store and leaves the input free for the next item
// a draw item runs two setup steps (SETUP and MUL, the multiplies) and then reads one row per cycle while the
// output does not stall, min(glyph_height, 32) rows, paced by the single read port of the font store
// the next item is taken once the last row of a draw has been read
// output stall holds rows in the output register and read stage, reads pause meanwhile
// synchronous active-low reset clears control and config, not the font store
module glyph_row_renderer_core import grr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  logic               i_out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    logic [PITCH_W-1:0]  r_pitch;
    logic [HEIGHT_W-1:0] r_height;
    logic [WORDS_W-1:0]  r_words;
    logic [CWIDTH_W-1:0] r_cwidth;
    logic [COLOR_W-1:0]  r_fg;
    logic [COLOR_W-1:0]  r_bg;

    logic [CODE_W-1:0]    r_code;
    logic [CODE_W-1:0]    r_col;
    logic [CODE_W-1:0]    r_crow;
    logic [YBASE_W-1:0]   r_ybase;
    logic [COLOFF_W-1:0]  r_coloff;
    logic [ROW_W-1:0]     r_rows;
    logic [ROW_W-1:0]     r_row;
    logic [AW-1:0]        r_addr;
    logic [PIX_IDX_W-1:0] r_idx;

    logic                 r_rd_valid;
    logic [PIX_IDX_W-1:0] r_rd_idx;
    logic                 r_rd_last;
    logic                 r_out_valid;
    t_out_item            r_out_data;
    t_out_item            n_out_data;

    logic                   in_acc;
    logic                   ld_we;
    logic [LD_W-1:0]        ld_addr_ext;
    logic [BASE_W-1:0]      base_prod;
    logic [IDX_SUM_W-1:0]   idx_sum;
    logic                   row_last;
    logic                   rd_take;
    logic                   out_pop;
    logic                   issue;
    logic [FONT_WORD_W-1:0] rd_word;
    logic                   cfg_we;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign ld_we       = in_acc && (i_in_data.func == FUNC_LOAD);
    assign ld_addr_ext = LD_W'(i_in_data.font_addr);
    assign base_prod   = BASE_W'(r_code) * BASE_W'(r_words);
    assign idx_sum     = IDX_SUM_W'(r_ybase) * IDX_SUM_W'(r_pitch) + IDX_SUM_W'(r_coloff);
    assign row_last    = ((ROW_W + 1)'(r_row) + (ROW_W + 1)'(1)) == (ROW_W + 1)'(r_rows);
    assign out_pop     = r_out_valid && !i_out_stall;
    assign rd_take     = r_rd_valid && (!r_out_valid || !i_out_stall);
    assign issue       = (r_state == ST_RUN) && (!r_rd_valid || rd_take);

    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    grr_ram #(
        .WIDTH(FONT_WORD_W),
        .DEPTH(FONT_WORDS)
    ) u_font_ram (
        .i_clk  (i_clk),
        .i_we   (ld_we),
        .i_waddr(ld_addr_ext[AW-1:0]),
        .i_wdata(i_in_data.font_word),
        .i_re   (issue),
        .i_raddr(r_addr),
        .o_rdata(rd_word)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.func == FUNC_DRAW)) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                // zero glyph height gives no rows
                n_state = (r_rows == '0) ? ST_IDLE : ST_RUN;
            end
            ST_RUN: begin
                if (issue && row_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // draw sequencer datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code <= i_in_data.char_code;
            r_col  <= i_in_data.char_col;
            r_crow <= i_in_data.char_row;
        end
        if (r_state == ST_SETUP) begin
            r_addr   <= base_prod[AW-1:0];
            r_ybase  <= YBASE_W'(r_crow) * YBASE_W'(r_height);
            r_coloff <= COLOFF_W'(r_col) * COLOFF_W'(r_cwidth);
            r_rows   <= (int'(r_height) > MAX_GLYPH_ROWS) ? ROW_W'(MAX_GLYPH_ROWS)
                                                          : ROW_W'(r_height);
        end
        if (r_state == ST_MUL) begin
            r_idx <= idx_sum[PIX_IDX_W-1:0];
            r_row <= '0;
        end
        if (issue) begin
            r_idx    <= r_idx + PIX_IDX_W'(r_pitch);
            r_addr   <= r_addr + AW'(1);
            r_row    <= r_row + ROW_W'(1);
            r_rd_idx <= r_idx;
            r_rd_last <= row_last;
        end
    end

    // read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_rd_valid <= 1'b1;
            end else if (rd_take) begin
                r_rd_valid <= 1'b0;
            end
            if (rd_take) begin
                r_out_valid <= 1'b1;
            end else if (out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pixels 0..7 from the high byte msb first, pixels 8 and 9 from bits 7 and 6
    always_comb begin
        n_out_data.pixel_index = r_rd_idx;
        n_out_data.color_0     = rd_word[15] ? r_fg : r_bg;
        n_out_data.color_1     = rd_word[14] ? r_fg : r_bg;
        n_out_data.color_2     = rd_word[13] ? r_fg : r_bg;
        n_out_data.color_3     = rd_word[12] ? r_fg : r_bg;
        n_out_data.color_4     = rd_word[11] ? r_fg : r_bg;
        n_out_data.color_5     = rd_word[10] ? r_fg : r_bg;
        n_out_data.color_6     = rd_word[9]  ? r_fg : r_bg;
        n_out_data.color_7     = rd_word[8]  ? r_fg : r_bg;
        n_out_data.color_8     = rd_word[7]  ? r_fg : r_bg;
        n_out_data.color_9     = rd_word[6]  ? r_fg : r_bg;
        n_out_data.last_row    = r_rd_last;
    end

    always_ff @(posedge i_clk) begin
        if (rd_take) begin
            r_out_data <= n_out_data;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch  <= RST_PITCH;
            r_height <= RST_HEIGHT;
            r_words  <= RST_WORDS;
            r_cwidth <= RST_CWIDTH;
            r_fg     <= RST_FG;
            r_bg     <= RST_BG;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_PITCH:  r_pitch  <= pwdata[PITCH_W-1:0];
                REG_HEIGHT: r_height <= pwdata[HEIGHT_W-1:0];
                REG_WORDS:  r_words  <= pwdata[WORDS_W-1:0];
                REG_CWIDTH: r_cwidth <= pwdata[CWIDTH_W-1:0];
                REG_FG:     r_fg     <= pwdata[COLOR_W-1:0];
                REG_BG:     r_bg     <= pwdata[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PITCH:  prdata = PDATA_W'(r_pitch);
            REG_HEIGHT: prdata = PDATA_W'(r_height);
            REG_WORDS:  prdata = PDATA_W'(r_words);
            REG_CWIDTH: prdata = PDATA_W'(r_cwidth);
            REG_FG:     prdata = PDATA_W'(r_fg);
            REG_BG:     prdata = PDATA_W'(r_bg);
            default:    prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/core/grr_checker.sv
`include "glyph_row_renderer_core_defines.svh"

module grr_checker import grr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    logic in_draw;
    logic in_load;
    logic out_held;

    assign in_draw  = i_in_valid && !o_in_stall && (i_in_data.func == FUNC_DRAW);
    assign in_load  = i_in_valid && !o_in_stall && (i_in_data.func == FUNC_LOAD);
    assign out_held = o_out_valid && i_out_stall;

    // a stalled row stays offered unchanged
    `GRR_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(o_out_data), "stalled row lost")

    // a draw occupies the sequencer for its setup
    `GRR_ASSERT_NEXT(a_draw_busy, in_draw, o_in_stall, "draw item did not start the sequencer")

    // a load leaves the input free for the next item
    `GRR_ASSERT_NEXT(a_load_free, in_load, !o_in_stall, "load item blocked the input")

    // no row leaves straight out of reset
    `GRR_ASSERT_NOW(a_rst_quiet, $rose(i_rst_n), !o_out_valid, "output valid right after reset")

endmodule

bind glyph_row_renderer_core grr_checker u_grr_checker (.*);
